FILE: src/m68kea_pkg.sv
`default_nettype none

package m68kea_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [1:0] {
    OP_CALC    = 2'd0,
    OP_WR_DREG = 2'd1,
    OP_WR_AREG = 2'd2,
    OP_LD_PC   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_DREG    = 3'd0,
    MODE_AREG    = 3'd1,
    MODE_IND     = 3'd2,
    MODE_POSTINC = 3'd3,
    MODE_PREDEC  = 3'd4,
    MODE_DISP    = 3'd5,
    MODE_INDEX   = 3'd6,
    MODE_EXT     = 3'd7
  } mode_e;

  // register field codes under mode 7
  localparam logic [2:0] ExtAbsShort = 3'd0;
  localparam logic [2:0] ExtAbsLong  = 3'd1;
  localparam logic [2:0] ExtPcDisp   = 3'd2;
  localparam logic [2:0] ExtPcIndex  = 3'd3;
  localparam logic [2:0] ExtImm      = 3'd4;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeWord = 2'd1;
  localparam logic [1:0] SizeLong = 2'd2;

  typedef struct packed {
    op_e          op;
    mode_e        mode;
    logic [2:0]   reg_field;
    logic [1:0]   op_size;
    logic [15:0]  ext_word_first;
    logic [15:0]  ext_word_second;
    logic [31:0]  write_value;
  } req_t;

  typedef struct packed {
    logic [31:0] effective_address;
    logic [1:0]  ext_words_used;
    logic        addr_reg_updated;
    logic [31:0] pc_after;
    logic        mode_invalid;
  } res_t;

  typedef struct packed {
    logic               dreg_we;
    logic               areg_we;
    logic [RegIdxW-1:0] wr_idx;
    logic [AddrW-1:0]   wr_val;
    logic [AddrW-1:0]   pc_val;
  } wb_t;

endpackage

`default_nettype wire

FILE: src/m68kea_regs.sv
`default_nettype none

module m68kea_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire m68kea_pkg::wb_t          wb_i,
  output logic [m68kea_pkg::AddrW-1:0]  dreg_o [m68kea_pkg::NumRegs],
  output logic [m68kea_pkg::AddrW-1:0]  areg_o [m68kea_pkg::NumRegs],
  output logic [m68kea_pkg::AddrW-1:0]  pc_o
);

  logic [m68kea_pkg::AddrW-1:0] dreg_q [m68kea_pkg::NumRegs];
  logic [m68kea_pkg::AddrW-1:0] areg_q [m68kea_pkg::NumRegs];
  logic [m68kea_pkg::AddrW-1:0] pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < m68kea_pkg::NumRegs; i++) begin
        dreg_q[i] <= '0;
        areg_q[i] <= '0;
      end
      pc_q <= '0;
    end else if (we_i) begin
      if (wb_i.dreg_we) begin
        dreg_q[wb_i.wr_idx] <= wb_i.wr_val;
      end
      if (wb_i.areg_we) begin
        areg_q[wb_i.wr_idx] <= wb_i.wr_val;
      end
      pc_q <= wb_i.pc_val;
    end
  end

  assign dreg_o = dreg_q;
  assign areg_o = areg_q;
  assign pc_o   = pc_q;

endmodule

`default_nettype wire

FILE: src/m68kea_calc.sv
`default_nettype none

module m68kea_calc (
  input  wire m68kea_pkg::req_t              req_i,
  input  wire logic [m68kea_pkg::AddrW-1:0]  dreg_i [m68kea_pkg::NumRegs],
  input  wire logic [m68kea_pkg::AddrW-1:0]  areg_i [m68kea_pkg::NumRegs],
  input  wire logic [m68kea_pkg::AddrW-1:0]  pc_i,
  output m68kea_pkg::res_t                   res_o,
  output m68kea_pkg::wb_t                    wb_o
);

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  logic [31:0] an;
  logic [31:0] idx_raw;
  logic [31:0] idx_ext;
  logic [31:0] idx_scaled;
  logic [31:0] brief_base;
  logic [31:0] brief_ea;
  logic [2:0]  step;
  logic [31:0] ea;
  logic [1:0]  used;
  logic        upd;
  logic        inval;
  logic [31:0] pc_next;

  assign an = areg_i[req_i.reg_field];

  // brief extension word: D/A, register, W/L, scale, 8-bit displacement
  always_comb begin
    idx_raw    = req_i.ext_word_first[15] ? areg_i[req_i.ext_word_first[14:12]]
                                          : dreg_i[req_i.ext_word_first[14:12]];
    idx_ext    = req_i.ext_word_first[11] ? idx_raw : sext16(idx_raw[15:0]);
    idx_scaled = idx_ext << req_i.ext_word_first[10:9];
    brief_base = (req_i.mode == m68kea_pkg::MODE_EXT) ? pc_i : an;
    // full extension format is not handled: address reads as zero
    brief_ea   = req_i.ext_word_first[8] ? '0
               : brief_base + idx_scaled + sext8(req_i.ext_word_first[7:0]);
  end

  always_comb begin
    case (req_i.op_size)
      m68kea_pkg::SizeByte: step = 3'd1;
      m68kea_pkg::SizeWord: step = 3'd2;
      m68kea_pkg::SizeLong: step = 3'd4;
      default:              step = 3'd0;
    endcase
  end

  always_comb begin
    ea      = '0;
    used    = '0;
    upd     = 1'b0;
    inval   = 1'b0;
    pc_next = pc_i;
    wb_o    = '0;
    wb_o.wr_idx = req_i.reg_field;
    wb_o.wr_val = req_i.write_value;

    unique case (req_i.op)
      m68kea_pkg::OP_WR_DREG: wb_o.dreg_we = 1'b1;
      m68kea_pkg::OP_WR_AREG: wb_o.areg_we = 1'b1;
      m68kea_pkg::OP_LD_PC:   pc_next = req_i.write_value;
      default: begin
        unique case (req_i.mode)
          m68kea_pkg::MODE_DREG, m68kea_pkg::MODE_AREG: begin
            ea = {29'd0, req_i.reg_field};
          end
          m68kea_pkg::MODE_IND: ea = an;
          m68kea_pkg::MODE_POSTINC: begin
            ea           = an;
            wb_o.areg_we = 1'b1;
            wb_o.wr_val  = an + {29'd0, step};
            upd          = (step != 3'd0);
          end
          m68kea_pkg::MODE_PREDEC: begin
            ea           = an - {29'd0, step};
            wb_o.areg_we = 1'b1;
            wb_o.wr_val  = an - {29'd0, step};
            upd          = (step != 3'd0);
          end
          m68kea_pkg::MODE_DISP: begin
            ea   = an + sext16(req_i.ext_word_first);
            used = 2'd1;
          end
          m68kea_pkg::MODE_INDEX: begin
            ea   = brief_ea;
            used = 2'd1;
          end
          default: begin
            unique case (req_i.reg_field)
              m68kea_pkg::ExtAbsShort: begin
                ea   = sext16(req_i.ext_word_first);
                used = 2'd1;
              end
              m68kea_pkg::ExtAbsLong: begin
                ea   = {req_i.ext_word_first, req_i.ext_word_second};
                used = 2'd2;
              end
              m68kea_pkg::ExtPcDisp: begin
                ea   = pc_i + sext16(req_i.ext_word_first);
                used = 2'd1;
              end
              m68kea_pkg::ExtPcIndex: begin
                ea   = brief_ea;
                used = 2'd1;
              end
              m68kea_pkg::ExtImm: begin
                // byte immediate sits in the low byte of its word
                ea   = (req_i.op_size == m68kea_pkg::SizeByte) ? pc_i + 32'd1 : pc_i;
                used = (req_i.op_size == m68kea_pkg::SizeLong) ? 2'd2 : 2'd1;
              end
              default: inval = 1'b1;
            endcase
          end
        endcase
        pc_next = pc_i + {29'd0, used, 1'b0};
      end
    endcase

    wb_o.pc_val = pc_next;

    res_o.effective_address = ea;
    res_o.ext_words_used    = used;
    res_o.addr_reg_updated  = upd;
    res_o.pc_after          = pc_next;
    res_o.mode_invalid      = inval;
  end

endmodule

`default_nettype wire

FILE: src/m68k_effective_address_unit.sv
`default_nettype none

// An accepted beat passes the input register, then the result register. Throughput:
// one beat per cycle unless the master side stalls; the register file is updated as an
// item leaves the input register, so the next item already sees the write-back.
// Reset: rst_ni clears the data, address and PC registers and both valid flags.

module m68k_effective_address_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [2:0] mode, [5:3] reg_field, [7:6] op_size, [23:8] ext_word_first,
  // [39:24] ext_word_second, [71:40] write_value
  input  wire logic [m68kea_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] effective_address, [33:32] ext_words_used, [34] addr_reg_updated,
  // [66:35] pc_after, [67] mode_invalid, [71:68] zero
  output logic [m68kea_pkg::OutDataW-1:0]        m_axis_tdata
);

  m68kea_pkg::req_t req_d, req_q;
  logic             in_valid_q;
  m68kea_pkg::res_t res_d, res_q;
  logic             out_valid_q;
  logic             advance;
  m68kea_pkg::wb_t  wb;

  logic [m68kea_pkg::AddrW-1:0] dreg [m68kea_pkg::NumRegs];
  logic [m68kea_pkg::AddrW-1:0] areg [m68kea_pkg::NumRegs];
  logic [m68kea_pkg::AddrW-1:0] pc;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    req_d.op              = m68kea_pkg::op_e'(s_axis_tuser);
    req_d.mode            = m68kea_pkg::mode_e'(s_axis_tdata[2:0]);
    req_d.reg_field       = s_axis_tdata[5:3];
    req_d.op_size         = s_axis_tdata[7:6];
    req_d.ext_word_first  = s_axis_tdata[23:8];
    req_d.ext_word_second = s_axis_tdata[39:24];
    req_d.write_value     = s_axis_tdata[71:40];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q <= req_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  m68kea_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (advance),
    .wb_i   (wb),
    .dreg_o (dreg),
    .areg_o (areg),
    .pc_o   (pc)
  );

  m68kea_calc u_calc (
    .req_i  (req_q),
    .dreg_i (dreg),
    .areg_i (areg),
    .pc_i   (pc),
    .res_o  (res_d),
    .wb_o   (wb)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, res_q.mode_invalid, res_q.pc_after, res_q.addr_reg_updated,
                          res_q.ext_words_used, res_q.effective_address};

  // an item leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  // a held item keeps its payload until it moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(req_q))
    else $error("stalled input item lost or changed");

  // unsupported modes consume nothing and leave the PC alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.mode_invalid |->
      res_d.ext_words_used == 2'd0 && res_d.pc_after == pc && res_d.effective_address == '0)
    else $error("invalid mode produced side effects");

  // step modes use no extension words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.addr_reg_updated |-> res_d.ext_words_used == 2'd0 && wb.areg_we)
    else $error("address register update inconsistent");

  // PC register follows the reported pc_after of each result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> pc == res_q.pc_after)
    else $error("PC does not match reported pc_after");

endmodule

`default_nettype wire
